FILE: sv/ibcd_pkg.sv
`timescale 1ns / 1ps

package ibcd_pkg;

   // Field and arithmetic widths
   localparam int SAMPLE_W  = 24;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 64;
   localparam int ACC_W     = 36;
   localparam int FACTOR_W  = 7;
   localparam int COUNT_W   = 6;
   localparam int SEC_IDX_W = 3;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd8;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 7'd64;

   // Rounding term of the Q31 multiply
   localparam logic signed [PROD_W:0] ROUND_POS = 65'sh0_0000_0000_4000_0000;
   localparam logic signed [PROD_W:0] ROUND_NEG = -65'sh0_0000_0000_4000_0000;

   localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_MIN = -36'sh0_8000_0000;

   // Datapath step within one section
   typedef enum logic [2:0] {
      PH_B0X  = 3'd0,
      PH_B1X  = 3'd1,
      PH_A1Y  = 3'd2,
      PH_B2X  = 3'd3,
      PH_A2Y  = 3'd4,
      PH_LAST = 3'd5
   } phase_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                 load;
      logic                 run;
      phase_type            phase;
      logic [SEC_IDX_W-1:0] sec;
      logic                 out_load;
   } cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] b0;
      logic signed [DATA_W-1:0] b1;
      logic signed [DATA_W-1:0] b2;
      logic signed [DATA_W-1:0] a1;
      logic signed [DATA_W-1:0] a2;
   } coef_set_type;

   // Fixed section coefficients: two notches, then one-pole low-pass
   function automatic coef_set_type coef_of(input logic [SEC_IDX_W-1:0] sec);
      coef_set_type c;
      unique case (sec)
         3'd0: begin
            c.b0 = 32'sd1321528399;
            c.b1 = 32'sd0;
            c.b2 = 32'sd1321528399;
            c.a1 = 32'sd0;
            c.a2 = 32'sd495573150;
         end
         3'd1: begin
            c.b0 = 32'sd1489299873;
            c.b1 = 32'sd2106188079;
            c.b2 = 32'sd1489299873;
            c.a1 = 32'sd2106188079;
            c.a2 = 32'sd831116099;
         end
         default: begin
            c.b0 = 32'sd477240275;
            c.b1 = 32'sd0;
            c.b2 = 32'sd0;
            c.a1 = -32'sd1670243373;
            c.a2 = 32'sd0;
         end
      endcase
      return c;
   endfunction

   // Q31 scaling of a registered product: round away by sign, floor shift by 31
   function automatic logic signed [ACC_W-1:0] q31_of(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] r;
      logic signed [PROD_W:0] s;
      r = 65'(p) + (p[PROD_W-1] ? ROUND_NEG : ROUND_POS);
      s = r >>> 31;
      return s[ACC_W-1:0];
   endfunction

   // Clamp to signed 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/ibcd_datapath.sv
`timescale 1ns / 1ps

module ibcd_datapath import ibcd_pkg::*; #(
   parameter int SECTIONS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic [DATA_W-1:0]   rsp_data
);

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc1_ff, acc1_in;
   logic signed [ACC_W-1:0]  acc2_ff, acc2_in;
   logic [DATA_W-1:0]        out_ff;
   logic signed [DATA_W-1:0] z1_ff [SECTIONS];
   logic signed [DATA_W-1:0] z2_ff [SECTIONS];

   logic [SEC_W-1:0]         sec_idx;
   coef_set_type             coef;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [ACC_W-1:0]  q;
   logic signed [ACC_W-1:0]  z1_ext, z2_ext;
   logic                     z1_we, z2_we;
   logic signed [DATA_W-1:0] z1_wr, z2_wr;

   assign sec_idx = cmd.sec[SEC_W-1:0];
   assign coef    = coef_of(cmd.sec);
   assign q       = q31_of(prod_ff);
   assign z1_ext  = ACC_W'(z1_ff[sec_idx]);
   assign z2_ext  = ACC_W'(z2_ff[sec_idx]);

   // Shared multiplier operand select
   always_comb begin
      case (cmd.phase)
         PH_B0X:  begin mul_a = coef.b0; mul_b = x_ff; end
         PH_B1X:  begin mul_a = coef.b1; mul_b = x_ff; end
         PH_A1Y:  begin mul_a = coef.a1; mul_b = y_ff; end
         PH_B2X:  begin mul_a = coef.b2; mul_b = x_ff; end
         PH_A2Y:  begin mul_a = coef.a2; mul_b = y_ff; end
         default: begin mul_a = coef.b0; mul_b = x_ff; end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Accumulate the product registered one step earlier
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      z1_we   = 1'b0;
      z2_we   = 1'b0;
      z1_wr   = sat32(acc1_ff);
      z2_wr   = sat32(acc2_ff - q);
      if (cmd.load) begin
         x_in = DATA_W'(signed'(req_sample));
      end else if (cmd.run) begin
         case (cmd.phase)
            PH_B1X:  y_in    = sat32(q + z1_ext);
            PH_A1Y:  acc1_in = q + z2_ext;
            PH_B2X:  acc1_in = acc1_ff - q;
            PH_A2Y: begin
               acc2_in = q;
               z1_we   = 1'b1;
            end
            PH_LAST: begin
               z2_we = 1'b1;
               x_in  = y_ff;
            end
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      prod_ff <= prod_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      if (cmd.out_load) begin
         out_ff <= x_ff;
      end
   end

   // Section delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SECTIONS; k++) begin
            z1_ff[k] <= '0;
            z2_ff[k] <= '0;
         end
      end else begin
         if (z1_we) begin
            z1_ff[sec_idx] <= z1_wr;
         end
         if (z2_we) begin
            z2_ff[sec_idx] <= z2_wr;
         end
      end
   end

   assign rsp_data = out_ff;

endmodule

FILE: sv/ibcd_controller.sv
`timescale 1ns / 1ps

module ibcd_controller import ibcd_pkg::*; #(
   parameter int SECTIONS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data,
   output cmd_type             cmd
);

   localparam logic [SEC_IDX_W-1:0] LAST_SEC = SEC_IDX_W'(SECTIONS - 1);

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [SEC_IDX_W-1:0] sec_ff, sec_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FACTOR_W-1:0]  factor_ff, factor_in;
   logic                 emit_ff, emit_in;
   logic                 valid_ff, valid_in;

   logic                 req_xfer;
   logic                 out_load;
   logic [FACTOR_W-1:0]  factor_eff;
   logic [FACTOR_W-1:0]  count_next;
   logic                 emit_now;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_tvalid = valid_ff;

   // Decimation decision taken as the sample is accepted
   assign factor_eff = (factor_ff > FACTOR_MAX) ? FACTOR_MAX : factor_ff;
   assign count_next = FACTOR_W'(count_ff) + 7'd1;
   assign emit_now   = (count_next >= factor_eff);

   // Result loads when the output register is free or draining this cycle
   assign out_load = (state_ff == ST_DONE) && emit_ff && (!valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      sec_in    = sec_ff;
      count_in  = count_ff;
      emit_in   = emit_ff;
      factor_in = factor_ff;
      valid_in  = valid_ff;

      if (csr_valid && csr_ready) begin
         factor_in = csr_data;
      end
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (out_load) begin
         valid_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_RUN;
               phase_in = PH_B0X;
               sec_in   = '0;
               emit_in  = emit_now;
               count_in = emit_now ? '0 : count_next[COUNT_W-1:0];
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_LAST) begin
               phase_in = PH_B0X;
               if (sec_ff == LAST_SEC) begin
                  state_in = ST_DONE;
               end else begin
                  sec_in = sec_ff + 3'd1;
               end
            end else begin
               phase_in = phase_type'(phase_ff + 3'd1);
            end
         end
         ST_DONE: begin
            if (!emit_ff || out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_B0X;
         sec_ff    <= '0;
         count_ff  <= '0;
         emit_ff   <= 1'b0;
         factor_ff <= FACTOR_RESET;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         sec_ff    <= sec_in;
         count_ff  <= count_in;
         emit_ff   <= emit_in;
         factor_ff <= factor_in;
         valid_ff  <= valid_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd.load     = req_xfer;
      cmd.run      = (state_ff == ST_RUN);
      cmd.phase    = phase_ff;
      cmd.sec      = sec_ff;
      cmd.out_load = out_load;
   end

endmodule

FILE: sv/iir_biquad_cascade_decimator_unit.sv
`timescale 1ns / 1ps
// A sample is accepted in ST_IDLE, filtered through every section in ST_RUN and, if due,
// loaded into the output register in ST_DONE, which waits while that register is held full.
// Each section takes six steps around the single shared 32x32 multiplier; a new sample is
// accepted only back in ST_IDLE. Only every decimation_factor-th sample (0 acts as 1, above
// 64 as 64) produces a result transfer. Reset (synchronous, active high) clears the delay
// registers, the decimation count and the output valid, and sets decimation_factor to 8.

module iir_biquad_cascade_decimator_unit import ibcd_pkg::*; #(
   parameter int SECTIONS = 5
) (
   input  logic                clock,
   input  logic                reset,
   // req_tdata: [23:0] sample
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   // rsp_tdata: [31:0] cascade_out
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   // csr_data: [6:0] decimation_factor
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data
);

   cmd_type cmd;

   ibcd_controller #(
      .SECTIONS (SECTIONS)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd)
   );

   ibcd_datapath #(
      .SECTIONS (SECTIONS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_sample (req_tdata),
      .rsp_data   (rsp_tdata)
   );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import ibcd_pkg::*;

   localparam int N_SEC   = 5;
   localparam int LATENCY = 6 * N_SEC + 2;
   localparam int IDLE_PCT = 32;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7F_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h80_0000;

   localparam longint Q31_ROUND = 64'sd1073741824;
   localparam longint SAT_HI    = 64'sd2147483647;
   localparam longint SAT_LO    = -64'sd2147483648;

   // Stimulus shapes for the random part
   typedef enum int {
      PAT_NOISE   = 0,
      PAT_STEP    = 1,
      PAT_NYQUIST = 2,
      PAT_DRIFT   = 3,
      PAT_CORNER  = 4
   } pattern_type;

   typedef struct {
      int b0;
      int b1;
      int b2;
      int a1;
      int a2;
   } section_coef_type;

   // Two notches, then one-pole low-pass sections
   function automatic section_coef_type section_coef(int k);
      section_coef_type c;
      case (k)
         0: c = '{1321528399, 0, 1321528399, 0, 495573150};
         1: c = '{1489299873, 2106188079, 1489299873, 2106188079, 831116099};
         default: c = '{477240275, 0, 0, -1670243373, 0};
      endcase
      return c;
   endfunction

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [FACTOR_W-1:0] csr_data   = '0;
   logic                calm       = 1'b0;

   // Filter cascade and decimator predictor plus the queue of results due
   class cascade_checker;
      int                signed delay_first [N_SEC];
      int                signed delay_second [N_SEC];
      bit [COUNT_W-1:0]  skip_count;
      bit [FACTOR_W-1:0] factor;
      logic [DATA_W-1:0] filtered_due [$];
      int                mismatches;

      function new();
         factor = FACTOR_RESET;
      endfunction

      // Q31 multiply: round away from zero by sign, floor shift by 31
      function longint q31(int c, int v);
         longint p;
         p = longint'(c) * longint'(v);
         p = p + ((p < 0) ? -Q31_ROUND : Q31_ROUND);
         return p >>> 31;
      endfunction

      function int clamp32(longint v);
         if (v > SAT_HI) return int'(SAT_HI);
         if (v < SAT_LO) return int'(SAT_LO);
         return int'(v);
      endfunction

      // Run one accepted sample through the cascade and the decimator
      function void take_sample(logic [SAMPLE_W-1:0] raw);
         int               x;
         int               y;
         longint           n1;
         longint           n2;
         section_coef_type c;
         int unsigned      f;
         int unsigned      nxt;
         x = int'($signed(raw));
         for (int k = 0; k < N_SEC; k++) begin
            c  = section_coef(k);
            y  = clamp32(q31(c.b0, x) + longint'(delay_first[k]));
            n1 = q31(c.b1, x) + longint'(delay_second[k]) - q31(c.a1, y);
            n2 = q31(c.b2, x) - q31(c.a2, y);
            delay_first[k]  = clamp32(n1);
            delay_second[k] = clamp32(n2);
            x = y;
         end
         f   = (factor > FACTOR_MAX) ? FACTOR_MAX : factor;
         nxt = skip_count + 1;
         if (nxt >= f) begin
            skip_count = '0;
            filtered_due.push_back(x);
         end else begin
            skip_count = nxt[COUNT_W-1:0];
         end
      endfunction

      task report(string what);
         $display("ERROR @%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_filtered(logic [DATA_W-1:0] v);
         logic [DATA_W-1:0] due;
         if (filtered_due.size() == 0) begin
            report($sformatf("cascade_out %0d with nothing due", $signed(v)));
         end else begin
            due = filtered_due.pop_front();
            if (v !== due)
               report($sformatf("cascade_out %0d, want %0d", $signed(v), $signed(due)));
         end
      endtask
   endclass

   cascade_checker sb = new();

   always #5 clock = ~clock;

   iir_biquad_cascade_decimator_unit #(
      .SECTIONS(N_SEC)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < IDLE_PCT);
   endfunction

   // Result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_filtered(rsp_tdata);
         rsp_tready <= !idle_now();
      end
   end

   // Leaves req_tvalid high on return; drain, or the next call when it idles, lowers it
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.take_sample(s);
   endtask

   // Stop sending, wait for all results, then cover a sample still in flight
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.filtered_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_factor(input logic [FACTOR_W-1:0] f);
      csr_valid <= 1'b1;
      csr_data  <= f;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      sb.factor = f;
      csr_valid <= 1'b0;
   endtask

   // Runs of shaped samples: noise, steps, full-scale square, drift, corners
   task automatic run_random(input int n_items);
      pattern_type         kind;
      int                  run_len;
      logic [31:0]         base;
      logic [SAMPLE_W-1:0] s;
      int                  sent;
      sent = 0;
      while (sent < n_items) begin
         kind    = pattern_type'($urandom_range(4));
         run_len = $urandom_range(20, 4);
         base    = $urandom;
         for (int i = 0; i < run_len && sent < n_items; i++) begin
            case (kind)
               PAT_NOISE:   s = SAMPLE_W'($urandom);
               PAT_STEP:    s = base[SAMPLE_W-1:0];
               PAT_NYQUIST: s = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
               PAT_DRIFT:   s = base[SAMPLE_W-1:0] + SAMPLE_W'(i * $urandom_range(4096));
               default: begin
                  case ($urandom_range(3))
                     0: s = SAMPLE_MAX;
                     1: s = SAMPLE_MIN;
                     2: s = '0;
                     default: s = '1;
                  endcase
               end
            endcase
            send_sample(s);
            sent++;
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [SAMPLE_W-1:0] corners [24] = '{
         24'h00_0000, SAMPLE_MAX, SAMPLE_MIN, 24'hFF_FFFF, 24'h00_0001,
         24'h55_5555, 24'hAA_AAAA,
         SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
         SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
         SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
         24'h00_0000, 24'h00_0000, 24'h00_0000};
      // zero acts as one, 127 clamps to 64, 3 after 127 lowers it mid-count
      int unsigned phase_factor [8] = '{1, 0, 127, 3, 64, 2, 5, 1};
      int          phase_len    [8] = '{80, 40, 70, 60, 70, 80, 60, 60};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Corner samples at the reset factor
      foreach (corners[i]) send_sample(corners[i]);

      for (int p = 0; p < 8; p++) begin
         drain();
         write_factor(FACTOR_W'(phase_factor[p]));
         calm <= (p == 0);
         if (p == 5) begin
            run_random(phase_len[p] / 2);
            drain();
            run_random(phase_len[p] - phase_len[p] / 2);
         end else begin
            run_random(phase_len[p]);
         end
      end

      drain();
      if (sb.mismatches == 0) begin
         $display("iir_biquad_cascade_decimator_unit: match");
      end else begin
         $display("iir_biquad_cascade_decimator_unit: mismatch");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("iir_biquad_cascade_decimator_unit: mismatch");
      $finish;
   end

endmodule
